[src/csd_pkg.sv]
package csd_pkg;

  localparam int BUF_DEPTH_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 24;

  localparam int BASE_W     = 12;
  localparam int SPAN_W     = 12;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(1235);
  localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(1544);
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(58740);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_DELAY = 2'd0,
    CFG_SWEEP_SPAN = 2'd1,
    CFG_SWEEP_STEP = 2'd2
  } cfg_idx_e;

endpackage

[src/csd_if.sv]
interface csd_in_if #(
  parameter int SAMPLE_BITS = csd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface csd_out_if #(
  parameter int SAMPLE_BITS = csd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface csd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [csd_pkg::CFG_IDX_W-1:0]   index;
  logic [csd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/chorus_swept_delay.sv]
// A result passes the s1, s2 and s3 registers and the output register before it is valid.
// Throughput: one sample per cycle while the output is not stalled; the two tap reads
// and the sample write share one cycle on a memory with one write port and two read ports.
// A configuration write waits for the pipeline to drain and holds off input until accepted.
// Reset: control state clears, the registers take their default values, the sweep
// recenters and the delay line reads as silence until each entry has been written.
module chorus_swept_delay #(
  parameter int BUF_DEPTH   = csd_pkg::BUF_DEPTH_DEF,
  parameter int SAMPLE_BITS = csd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = csd_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  csd_in_if.sink    sample_i,
  csd_out_if.source sample_o,
  csd_cfg_if.sink   cfg_i
);
  import csd_pkg::*;

  localparam int IDX_W  = $clog2(BUF_DEPTH);
  localparam int IP_W   = (IDX_W > BASE_W) ? IDX_W : BASE_W;
  localparam int POS_W  = IP_W + FRAC_BITS;
  localparam int BND_W  = IP_W + 1;
  localparam int CMP_W  = BND_W + FRAC_BITS;
  localparam int WID_W  = ((CMP_W > STEP_W) ? CMP_W : STEP_W) + 1;
  localparam int RP_W   = IDX_W + FRAC_BITS;
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

  localparam logic [BND_W-1:0] CAP    = BND_W'(BUF_DEPTH - 2);
  localparam logic [WID_W-1:0] PLIMIT = (WID_W'(BUF_DEPTH) << FRAC_BITS) - WID_W'(1);
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  function automatic logic [BND_W-1:0] upper_f(logic [BASE_W-1:0] b, logic [SPAN_W-1:0] s);
    logic [BND_W-1:0] sum;
    sum = BND_W'(b) + BND_W'(s);
    return (sum > CAP) ? CAP : sum;
  endfunction

  function automatic logic [POS_W-1:0] center_f(logic [BASE_W-1:0] b, logic [SPAN_W-1:0] s);
    logic [BND_W:0] mid;
    mid = (BND_W + 1)'(b) + (BND_W + 1)'(upper_f(b, s));
    return {mid[IP_W:1], {FRAC_BITS{1'b0}}};
  endfunction

  logic [BASE_W-1:0] base_q, base_d;
  logic [SPAN_W-1:0] span_q, span_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              fall_q, fall_d;
  logic [IDX_W-1:0]  widx_q, widx_d;
  logic              wrap_q, wrap_d;

  logic              take_out, take3, take2, take1, in_fire, cfg_fire;
  logic [IDX_W-1:0]  widx_nxt, rd_a_idx, rd_b_idx;
  logic [RP_W-1:0]   rp;
  logic [WID_W-1:0]  pos_w, step_w, sweep_nxt, lo_w, hi_w;
  logic              recenter;

  logic signed [SAMPLE_BITS-1:0] mem [BUF_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;

  logic                          s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic signed [SAMPLE_BITS-1:0] smp1_q;
  logic [FRAC_BITS-1:0]          f1_q, f2_q;
  logic                          fwd_a1_q, fwd_b1_q, ok_a1_q, ok_b1_q;
  logic signed [SAMPLE_BITS-1:0] tap_a, tap_b;
  logic signed [SAMPLE_BITS:0]   diff_d, diff_q;
  logic signed [SAMPLE_BITS-1:0] a2_q, a3_q;
  logic signed [PROD_W-1:0]      prod_d, prod_q, rnd;
  logic signed [SAMPLE_BITS+1:0] res;
  logic signed [SAMPLE_BITS-1:0] out_d, out_q;

  assign take_out = !out_v_q || sample_o.ready;
  assign take3    = !s3_v_q || take_out;
  assign take2    = !s2_v_q || take3;
  assign take1    = !s1_v_q || take2;
  assign sample_i.ready = take1 && !cfg_i.valid;
  assign in_fire  = sample_i.valid && sample_i.ready;
  assign cfg_i.ready = !(s1_v_q || s2_v_q || s3_v_q || out_v_q);
  assign cfg_fire = cfg_i.valid && cfg_i.ready;

  assign widx_nxt = widx_q + IDX_W'(1);
  assign rp       = {widx_nxt, {FRAC_BITS{1'b0}}} - pos_q[RP_W-1:0];
  assign rd_a_idx = rp[RP_W-1:FRAC_BITS];
  assign rd_b_idx = rd_a_idx + IDX_W'(1);

  always_comb begin
    pos_w  = WID_W'(pos_q);
    step_w = WID_W'(step_q);
    lo_w   = WID_W'({BND_W'(base_q), {FRAC_BITS{1'b0}}});
    hi_w   = WID_W'({upper_f(base_q, span_q), {FRAC_BITS{1'b0}}});
    if (fall_q) begin
      sweep_nxt = (pos_w >= step_w) ? pos_w - step_w : '0;
    end else begin
      sweep_nxt = pos_w + step_w;
      if (sweep_nxt > PLIMIT) begin
        sweep_nxt = PLIMIT;
      end
    end
  end

  always_comb begin
    base_d   = base_q;
    span_d   = span_q;
    step_d   = step_q;
    pos_d    = pos_q;
    fall_d   = fall_q;
    widx_d   = widx_q;
    wrap_d   = wrap_q;
    recenter = 1'b0;
    if (cfg_fire) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_BASE_DELAY: begin
          base_d   = cfg_i.data[BASE_W-1:0];
          recenter = 1'b1;
        end
        CFG_SWEEP_SPAN: begin
          span_d   = cfg_i.data[SPAN_W-1:0];
          recenter = 1'b1;
        end
        CFG_SWEEP_STEP: begin
          step_d   = cfg_i.data[STEP_W-1:0];
          recenter = 1'b1;
        end
        default: recenter = 1'b0;
      endcase
      if (recenter) begin
        pos_d  = center_f(base_d, span_d);
        fall_d = 1'b0;
      end
    end else if (in_fire) begin
      widx_d = widx_nxt;
      wrap_d = wrap_q || (widx_q == IDX_W'(BUF_DEPTH - 1));
      pos_d  = sweep_nxt[POS_W-1:0];
      fall_d = fall_q ^ ((sweep_nxt >= hi_w) || (sweep_nxt <= lo_w));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RST;
      span_q <= SPAN_RST;
      step_q <= STEP_RST;
      pos_q  <= center_f(BASE_RST, SPAN_RST);
      fall_q <= 1'b0;
      widx_q <= '0;
      wrap_q <= 1'b0;
    end else begin
      base_q <= base_d;
      span_q <= span_d;
      step_q <= step_d;
      pos_q  <= pos_d;
      fall_q <= fall_d;
      widx_q <= widx_d;
      wrap_q <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem[widx_q] <= sample_i.sample_in;
      rd_a_q      <= mem[rd_a_idx];
      rd_b_q      <= mem[rd_b_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp1_q   <= sample_i.sample_in;
      f1_q     <= rp[FRAC_BITS-1:0];
      fwd_a1_q <= (rd_a_idx == widx_q);
      fwd_b1_q <= (rd_b_idx == widx_q);
      ok_a1_q  <= wrap_q || (rd_a_idx < widx_q);
      ok_b1_q  <= wrap_q || (rd_b_idx < widx_q);
    end
    if (take2 && s1_v_q) begin
      diff_q <= diff_d;
      a2_q   <= tap_a;
      f2_q   <= f1_q;
    end
    if (take3 && s2_v_q) begin
      prod_q <= prod_d;
      a3_q   <= a2_q;
    end
    if (take_out && s3_v_q) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    tap_a  = fwd_a1_q ? smp1_q : (ok_a1_q ? rd_a_q : '0);
    tap_b  = fwd_b1_q ? smp1_q : (ok_b1_q ? rd_b_q : '0);
    diff_d = {tap_b[SAMPLE_BITS-1], tap_b} - {tap_a[SAMPLE_BITS-1], tap_a};
    prod_d = PROD_W'(diff_q) * PROD_W'($signed({1'b0, f2_q}));
    rnd    = (prod_q + HALF) >>> FRAC_BITS;
    res    = $signed(rnd[SAMPLE_BITS+1:0]) + $signed({{2{a3_q[SAMPLE_BITS-1]}}, a3_q});
    out_d  = res[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take1) begin
        s1_v_q <= in_fire;
      end
      if (take2) begin
        s2_v_q <= s1_v_q;
      end
      if (take3) begin
        s3_v_q <= s2_v_q;
      end
      if (take_out) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  assign sample_o.valid      = out_v_q;
  assign sample_o.sample_out = out_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import csd_pkg::*;

  localparam int DEPTH = BUF_DEPTH_DEF;
  localparam int SB = SAMPLE_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [63:0] FRAC_ONE = 64'd1 << FB;
  localparam logic [63:0] POS_MAX = (64'(DEPTH) << FB) - 64'd1;
  localparam logic [SB-1:0] SIGN_BIT = SB'(1) << (SB - 1);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_DIRECTED = 30;
  localparam int PHASE_ITEMS = 350;

  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SB-1:0]         smp;
    bit                    has_exp;
    logic [SB-1:0]         exp_val;
  } stim_row_t;

  // With base_delay 1, sweep_span 0 and sweep_step 0 the tap sits exactly one sample
  // back, so every output equals the sample of the same transaction.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h000000, 1'b1, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h7FFFFF, 1'b1, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h800000, 1'b1, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'hFFFFFF, 1'b1, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h000001, 1'b1, 24'h000000},
    '{1'b1, CFG_BASE_DELAY, 24'hABC001, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, CFG_SWEEP_SPAN, 24'h000000, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, CFG_SWEEP_STEP, 24'h000000, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h800000, 1'b1, 24'h800000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h000000, 1'b1, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h555555, 1'b1, 24'h555555},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'hAAAAAA, 1'b1, 24'hAAAAAA},
    '{1'b1, CFG_SWEEP_STEP, 24'h800000, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h7FFFFF, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h800000, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h123456, 1'b0, 24'h000000},
    '{1'b1, CFG_BASE_DELAY, 24'hFFFFFF, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, CFG_SWEEP_SPAN, 24'hFFFFFF, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, CFG_SWEEP_STEP, 24'hFFFFFF, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h7FFFFF, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h800000, 1'b0, 24'h000000},
    '{1'b1, CFG_BASE_DELAY, 24'h000000, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, CFG_SWEEP_SPAN, 24'h000000, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h654321, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h800000, 1'b0, 24'h000000},
    '{1'b1, CFG_UNMAPPED,   24'h5A5A5A, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h7FFFFF, 1'b0, 24'h000000},
    '{1'b0, CFG_BASE_DELAY, 24'h000000, 24'h000000, 1'b0, 24'h000000}
  };

  logic clk_i;
  logic rst_ni;

  csd_in_if  in_ch ();
  csd_out_if out_ch ();
  csd_cfg_if cfg_ch ();

  chorus_swept_delay dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (in_ch),
    .sample_o (out_ch),
    .cfg_i    (cfg_ch)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  logic [SB-1:0]        tap_mem [DEPTH];
  logic [IDX_W-1:0]     head_idx;
  logic [63:0]          sweep_pos;
  logic                 sweep_down;
  logic [BASE_W-1:0]    cur_base;
  logic [SPAN_W-1:0]    cur_span;
  logic [STEP_W-1:0]    cur_step;

  logic signed [SB-1:0] due_samples [$];
  logic signed [SB-1:0] want_sample;
  int                   fail_count = 0;
  int                   in_idle_pct = 0;
  int                   out_stall_pct = 0;
  int                   quiet_cycles = 0;

  function automatic logic [63:0] sweep_ceiling();
    logic [63:0] hi;
    hi = 64'(cur_base) + 64'(cur_span);
    return (hi > 64'(DEPTH - 2)) ? 64'(DEPTH - 2) : hi;
  endfunction

  function automatic void recenter_sweep();
    sweep_pos = ((64'(cur_base) + sweep_ceiling()) >> 1) << FB;
    sweep_down = 1'b0;
  endfunction

  function automatic void reset_chorus();
    for (int k = 0; k < DEPTH; k++) tap_mem[k] = SIGN_BIT;
    head_idx = '0;
    cur_base = BASE_RST;
    cur_span = SPAN_RST;
    cur_step = STEP_RST;
    recenter_sweep();
  endfunction

  // Taps are kept offset-binary so that the blend works on unsigned values.
  function automatic logic signed [SB-1:0] chorus_sample(input logic signed [SB-1:0] s);
    logic [63:0]      rd;
    logic [63:0]      frac;
    logic [63:0]      a;
    logic [63:0]      b;
    logic [63:0]      acc;
    logic [IDX_W-1:0] i1;
    logic [IDX_W-1:0] i2;
    logic [SB-1:0]    y;
    tap_mem[head_idx] = s ^ SIGN_BIT;
    head_idx = head_idx + 1'b1;
    rd = ((64'(head_idx) << FB) - sweep_pos) & POS_MAX;
    i1 = rd[FB +: IDX_W];
    i2 = i1 + 1'b1;
    frac = rd & (FRAC_ONE - 64'd1);
    a = 64'(tap_mem[i1]);
    b = 64'(tap_mem[i2]);
    acc = a * (FRAC_ONE - frac) + b * frac + (FRAC_ONE >> 1);
    y = acc[FB +: SB] ^ SIGN_BIT;
    if (sweep_down) begin
      sweep_pos = (sweep_pos >= 64'(cur_step)) ? sweep_pos - 64'(cur_step) : 64'd0;
    end else begin
      sweep_pos = sweep_pos + 64'(cur_step);
      if (sweep_pos > POS_MAX) sweep_pos = POS_MAX;
    end
    if (sweep_pos >= (sweep_ceiling() << FB) || sweep_pos <= (64'(cur_base) << FB)) begin
      sweep_down = !sweep_down;
    end
    return y;
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return ~SIGN_BIT;
        1: return SIGN_BIT;
        2: return '0;
        default: return '1;
      endcase
    end
    return SB'($urandom);
  endfunction

  task automatic push_sample(input logic signed [SB-1:0] s, input bit typed,
                             input logic signed [SB-1:0] typed_val);
    logic signed [SB-1:0] y;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    y = chorus_sample(s);
    due_samples.push_back(typed ? typed_val : y);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_BASE_DELAY: begin
        cur_base = data[BASE_W-1:0];
        recenter_sweep();
      end
      CFG_SWEEP_SPAN: begin
        cur_span = data[SPAN_W-1:0];
        recenter_sweep();
      end
      CFG_SWEEP_STEP: begin
        cur_step = data[STEP_W-1:0];
        recenter_sweep();
      end
      default: begin
      end
    endcase
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_settings();
    logic [BASE_W-1:0]     b;
    logic [SPAN_W-1:0]     sp;
    logic [STEP_W-1:0]     st;
    logic [CFG_DATA_W-1:0] word;
    bit                    stray;
    case ($urandom_range(9))
      0: begin
        b = $urandom_range(1) ? BASE_W'('1) - BASE_W'($urandom_range(1))
                              : BASE_W'($urandom_range(1));
        sp = $urandom_range(1) ? '1 : '0;
        st = $urandom_range(1) ? '1 : '0;
      end
      1, 2: begin
        b = BASE_W'($urandom);
        sp = SPAN_W'($urandom);
        st = STEP_W'($urandom);
      end
      default: begin
        b = BASE_W'($urandom_range(1, 40));
        sp = SPAN_W'($urandom_range(0, 40));
        st = STEP_W'($urandom_range(0, 24'h200000));
      end
    endcase
    stray = ($urandom_range(3) == 0);
    settle();
    word = CFG_DATA_W'($urandom);
    word[BASE_W-1:0] = b;
    cfg_write(CFG_BASE_DELAY, word, 1'b0);
    word = CFG_DATA_W'($urandom);
    word[SPAN_W-1:0] = sp;
    cfg_write(CFG_SWEEP_SPAN, word, 1'b0);
    cfg_write(CFG_SWEEP_STEP, CFG_DATA_W'(st), !stray);
    if (stray) cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom), 1'b1);
  endtask

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (due_samples.size() == 0) begin
        fail_count++;
        if (fail_count <= 40) begin
          $display("%0t: sample_out %0d with no transaction outstanding", $time,
                   out_ch.sample_out);
        end
      end else begin
        want_sample = due_samples.pop_front();
        if (out_ch.sample_out !== want_sample) begin
          fail_count++;
          if (fail_count <= 40) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                     want_sample, out_ch.sample_out);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit last_write;
    int burst;
    int remaining;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    reset_chorus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) begin
      if (DIRECTED[k].is_cfg) begin
        last_write = (k == N_DIRECTED - 1) || !DIRECTED[k + 1].is_cfg;
        settle();
        cfg_write(DIRECTED[k].idx, DIRECTED[k].data, last_write);
      end else begin
        push_sample(DIRECTED[k].smp, DIRECTED[k].has_exp, DIRECTED[k].exp_val);
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          in_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct = 72;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct = 0;
          out_stall_pct = 72;
        end
        default: begin
          in_idle_pct = 29;
          out_stall_pct = 29;
        end
      endcase
      remaining = PHASE_ITEMS;
      while (remaining > 0) begin
        if ($urandom_range(4) == 0) begin
          settle();
          cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom), 1'b1);
        end else begin
          random_settings();
        end
        burst = $urandom_range(30, 110);
        if (burst > remaining) burst = remaining;
        repeat (burst) push_sample(pick_sample(), 1'b0, '0);
        remaining -= burst;
      end
    end

    in_ch.valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
src/csd_pkg.sv
src/csd_if.sv
src/chorus_swept_delay.sv
verif/tb_top.sv
